FILE: hdl/bcrf_pkg.sv
`default_nettype none

package bcrf_pkg;

    // Number format and iteration cap
    localparam int FRAC_BITS = 16;
    localparam int MAX_ITER  = 40;
    localparam int PASS_W    = $clog2(MAX_ITER + 1);

    // Configuration register map
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CUBIC  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONST  = CFG_IDX_W'(3);

    // Reset polynomial x^3 + x - 4
    localparam logic signed [31:0] ONE_Q       = 32'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [31:0] RST_CUBIC   = ONE_Q;
    localparam logic signed [31:0] RST_SQUARE  = 32'sd0;
    localparam logic signed [31:0] RST_LINEAR  = ONE_Q;
    localparam logic signed [31:0] RST_CONST   = 32'(-(64'sd4 <<< FRAC_BITS));

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] cubic;
        logic signed [31:0] square;
        logic signed [31:0] linear;
        logic signed [31:0] cnst;
    } coef_t;

    // Status of one polynomial evaluation, valid while done is high
    typedef struct packed {
        logic done;
        logic zero;
        logic neg;
    } eval_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bcrf_horner.sv
`default_nettype none

module bcrf_horner (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [31:0]        x,
    input  wire bcrf_pkg::coef_t           coef,
    output bcrf_pkg::eval_res_t            res
);

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_ADD
    } h_state_t;

    h_state_t            state_reg;
    logic [1:0]          step_reg;
    logic                done_reg;
    logic signed [31:0]  acc_reg;
    logic signed [31:0]  x_reg;
    logic signed [63:0]  prod_reg;

    logic signed [31:0]  coef_sel;
    logic signed [31:0]  scaled;
    logic signed [31:0]  acc_next;

    always_comb
    begin
        case (step_reg)
            2'd0:    coef_sel = coef.square;
            2'd1:    coef_sel = coef.linear;
            default: coef_sel = coef.cnst;
        endcase
    end

    // Arithmetic shift floors the product, then clamp, add, clamp
    assign scaled   = bcrf_pkg::sat32(prod_reg >>> bcrf_pkg::FRAC_BITS);
    assign acc_next = bcrf_pkg::sat32(64'(scaled) + 64'(coef_sel));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg   <= coef.cubic;
                        x_reg     <= x;
                        step_reg  <= 2'd0;
                        state_reg <= H_MUL;
                    end
                end
                H_MUL:
                begin
                    prod_reg  <= acc_reg * x_reg;
                    state_reg <= H_ADD;
                end
                H_ADD:
                begin
                    acc_reg <= acc_next;
                    if (step_reg == 2'd2)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= H_MUL;
                    end
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.zero = (acc_reg == 32'sd0);
    assign res.neg  = acc_reg[31];

endmodule

`default_nettype wire

FILE: hdl/bisection_cubic_root_finder_top.sv
`default_nettype none

// Bisection root finder for p(x) = c3*x^3 + c2*x^2 + c1*x + c0 in signed
// Q16.16. Each input transaction carries an interval [left_end, right_end]
// and a tolerance e; the block halves the interval until |a - b| <= 2e or
// until MAX_ITER passes have run, then returns the last midpoint in root and
// raises iter_limit_hit when the pass cap ended the search. The coefficients
// are written through the configuration port (index 0 cubic, 1 square,
// 2 linear, 3 constant; other indexes are ignored) and reset to x^3 + x - 4.
// Write them only while the block is idle. Every pass evaluates the
// polynomial twice, at the midpoint and at the left end, on one shared
// Horner unit with a single registered 32x32 multiplier (three multiply/add
// steps, each a registered multiply and then an add). in_ready is high only
// while no search is running; a finished result sits in the output register,
// so the next item can be accepted while the result is still waiting for
// out_ready.

module bisection_cubic_root_finder_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [bcrf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                         cfg_data,
    // input channel
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic signed [31:0]                  left_end,
    input  wire logic signed [31:0]                  right_end,
    input  wire logic [30:0]                         tolerance,
    // result channel
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic signed [31:0]                  root,
    output      logic                                iter_limit_hit
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MID,
        S_EVM_GO,
        S_EVM_WAIT,
        S_EVA_GO,
        S_EVA_WAIT,
        S_DECIDE,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    bcrf_pkg::coef_t                 coef_reg;

    logic signed [31:0]              a_reg;
    logic signed [31:0]              b_reg;
    logic signed [31:0]              mid_reg;
    logic [31:0]                     twice_e_reg;
    logic [bcrf_pkg::PASS_W-1:0]     pass_cnt_reg;
    logic                            sm_zero_reg;
    logic                            sm_neg_reg;
    logic                            sa_zero_reg;
    logic                            sa_neg_reg;
    logic                            hit_reg;

    logic                            out_valid_reg;
    logic signed [31:0]              root_reg;
    logic                            flag_reg;

    bcrf_pkg::eval_res_t             h_res;
    logic                            h_start;
    logic signed [31:0]              h_x;

    logic signed [32:0]              sum_ab;
    logic signed [32:0]              diff_ab;
    logic [32:0]                     abs_diff;
    logic                            tol_met;
    logic                            last_pass;
    logic                            take_b;
    logic                            out_free;

    // ------------------------------------------------------------------
    // Shared polynomial unit: midpoint first, then left end
    // ------------------------------------------------------------------
    assign h_start = (state_reg == S_EVM_GO) || (state_reg == S_EVA_GO);
    assign h_x     = (state_reg == S_EVA_GO) ? a_reg : mid_reg;

    bcrf_horner u_horner (
        .clk   (clk),
        .rst_n (rst_n),
        .start (h_start),
        .x     (h_x),
        .coef  (coef_reg),
        .res   (h_res)
    );

    // Midpoint: 33-bit sum halved toward minus infinity
    assign sum_ab   = 33'(a_reg) + 33'(b_reg);

    // Stop test on the updated interval, exact in 33 bits
    assign diff_ab  = 33'(a_reg) - 33'(b_reg);
    assign abs_diff = diff_ab[32] ? 33'(-diff_ab) : 33'(diff_ab);
    assign tol_met  = (abs_diff <= {1'b0, twice_e_reg});
    assign last_pass = (pass_cnt_reg == bcrf_pkg::PASS_W'(bcrf_pkg::MAX_ITER - 1));

    // p(mid) * p(a) <= 0, by signs alone
    assign take_b   = sm_zero_reg || sa_zero_reg || (sm_neg_reg != sa_neg_reg);

    // Output register can take a new result
    assign out_free = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            pass_cnt_reg    <= '0;
            coef_reg.cubic  <= bcrf_pkg::RST_CUBIC;
            coef_reg.square <= bcrf_pkg::RST_SQUARE;
            coef_reg.linear <= bcrf_pkg::RST_LINEAR;
            coef_reg.cnst   <= bcrf_pkg::RST_CONST;
        end
        else
        begin
            // Coefficient writes; unknown indexes drop silently
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bcrf_pkg::CFG_COEF_CUBIC:  coef_reg.cubic  <= cfg_data;
                    bcrf_pkg::CFG_COEF_SQUARE: coef_reg.square <= cfg_data;
                    bcrf_pkg::CFG_COEF_LINEAR: coef_reg.linear <= cfg_data;
                    bcrf_pkg::CFG_COEF_CONST:  coef_reg.cnst   <= cfg_data;
                    default: ;
                endcase
            end

            // Retire the held result once taken; a finishing search reloads it
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg        <= left_end;
                        b_reg        <= right_end;
                        twice_e_reg  <= {tolerance, 1'b0};
                        pass_cnt_reg <= '0;
                        state_reg    <= S_MID;
                    end
                end
                S_MID:
                begin
                    mid_reg   <= sum_ab[32:1];
                    state_reg <= S_EVM_GO;
                end
                S_EVM_GO:
                begin
                    state_reg <= S_EVM_WAIT;
                end
                S_EVM_WAIT:
                begin
                    if (h_res.done)
                    begin
                        sm_zero_reg <= h_res.zero;
                        sm_neg_reg  <= h_res.neg;
                        state_reg   <= S_EVA_GO;
                    end
                end
                S_EVA_GO:
                begin
                    state_reg <= S_EVA_WAIT;
                end
                S_EVA_WAIT:
                begin
                    if (h_res.done)
                    begin
                        sa_zero_reg <= h_res.zero;
                        sa_neg_reg  <= h_res.neg;
                        state_reg   <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (take_b)
                    begin
                        b_reg <= mid_reg;
                    end
                    else
                    begin
                        a_reg <= mid_reg;
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (tol_met || last_pass)
                    begin
                        hit_reg   <= !tol_met;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        pass_cnt_reg <= pass_cnt_reg + bcrf_pkg::PASS_W'(1);
                        state_reg    <= S_MID;
                    end
                end
                S_FINISH:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        root_reg      <= mid_reg;
                        flag_reg      <= hit_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign root           = root_reg;
    assign iter_limit_hit = flag_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Evaluation results only arrive while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        h_res.done |-> (state_reg == S_EVM_WAIT || state_reg == S_EVA_WAIT))
        else $error("polynomial result arrived outside a wait state");

    // Pass counter never runs past the cap
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_cnt_reg <= bcrf_pkg::PASS_W'(bcrf_pkg::MAX_ITER - 1))
        else $error("pass counter beyond iteration cap");

    // A capped result only comes from the last allowed pass
    a_cap_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free && hit_reg) |-> last_pass)
        else $error("cap flag set before the last pass");

    // Finishing loads the output register with the last midpoint
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free)
            |=> (out_valid_reg && root_reg == $past(mid_reg)))
        else $error("result not loaded on finish");

endmodule

`default_nettype wire

FILE: bench/bisection_cubic_root_finder_top_tb.sv
module bisection_cubic_root_finder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Q16.16 landmarks used by the directed items
    localparam logic signed [31:0] Q1       = bcrf_pkg::ONE_Q;
    localparam logic signed [31:0] Q_TOP    = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_BOTTOM = 32'sh80000000;
    localparam logic [30:0]        TOL_TOP  = 31'h7FFFFFFF;

    // Indexes outside the register map; writes to them must change nothing
    localparam logic [bcrf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = bcrf_pkg::CFG_IDX_W'(4);
    localparam logic [bcrf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = bcrf_pkg::CFG_IDX_W'(15);

    // Worst-case search budget for an item that runs all MAX_ITER passes
    localparam int ITEM_CYCLES  = 19 * bcrf_pkg::MAX_ITER + 2;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 3000;
    // Budget: every transaction at the pass cap with a long output stall,
    // plus the hold-off and the config traffic, then four times that
    localparam int ITEM_BUDGET  = RANDOM_ITEMS + 100;
    localparam int CYCLE_LIMIT  =
        4 * (ITEM_BUDGET * (ITEM_CYCLES + 64) + HOLD_CYCLES + 100000);

    typedef struct {
        logic signed [31:0] root;
        logic               limit_hit;
    } root_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [bcrf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [31:0]     left_end;
    logic signed [31:0]     right_end;
    logic [30:0]            tolerance;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [31:0]     root;
    logic                   iter_limit_hit;

    // Shadow copy of the coefficient registers, indexed by register index
    logic signed [31:0]     coef_q [4];
    root_result_t           expected_roots [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_len      = 0;
    logic        hold_results  = 1'b0;
    int          mismatches    = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          cap_hits      = 0;
    int          poly_settings = 0;
    int unsigned cycle_count   = 0;

    bisection_cubic_root_finder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_end       (left_end),
        .right_end      (right_end),
        .tolerance      (tolerance),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .root           (root),
        .iter_limit_hit (iter_limit_hit)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp a 64-bit intermediate into the signed 32-bit range
    function automatic longint clamp32(input longint v);
        if (v > longint'(Q_TOP))
            return longint'(Q_TOP);
        if (v < longint'(Q_BOTTOM))
            return longint'(Q_BOTTOM);
        return v;
    endfunction

    // One Horner multiply/add: the exact product is floored back to Q16.16
    // by an arithmetic shift, then clamped, then the coefficient is added
    function automatic longint horner_step(input longint acc, input longint x,
                                           input longint c);
        longint scaled;
        scaled = clamp32((acc * x) >>> bcrf_pkg::FRAC_BITS);
        return clamp32(scaled + c);
    endfunction

    function automatic longint eval_poly(input longint x);
        longint acc;
        acc = coef_q[bcrf_pkg::CFG_COEF_CUBIC];
        acc = horner_step(acc, x, coef_q[bcrf_pkg::CFG_COEF_SQUARE]);
        acc = horner_step(acc, x, coef_q[bcrf_pkg::CFG_COEF_LINEAR]);
        acc = horner_step(acc, x, coef_q[bcrf_pkg::CFG_COEF_CONST]);
        return acc;
    endfunction

    // Run the whole search on the shadow coefficients
    function automatic void predict_bisection(input logic signed [31:0] a_in,
                                              input logic signed [31:0] b_in,
                                              input logic [30:0] e_in,
                                              output logic signed [31:0] mid_out,
                                              output logic capped);
        longint a, b, mid, twice_e, span, pm, pa;
        bit     met;
        int     pass;
        a       = a_in;
        b       = b_in;
        twice_e = 2 * longint'(e_in);
        mid     = a;
        met     = 1'b0;
        for (pass = 0; pass < bcrf_pkg::MAX_ITER && !met; pass++) begin
            // floor of the 33-bit sum over two
            mid = (a + b) >>> 1;
            pm  = eval_poly(mid);
            pa  = eval_poly(a);
            // a zero at either point or a sign change keeps the left half
            if (pm == 0 || pa == 0 || ((pm < 0) != (pa < 0)))
                b = mid;
            else
                a = mid;
            span = (a > b) ? a - b : b - a;
            met  = (span <= twice_e);
        end
        mid_out = mid[31:0];
        capped  = !met;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers (all inputs change on the falling edge)
    // ------------------------------------------------------------------

    // Drop both request channels and hold until every result is back
    task automatic wait_idle();
        in_valid  = 1'b0;
        cfg_valid = 1'b0;
        while (expected_roots.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; valid stays up so back-to-back writes never dip
    task automatic write_coef(input logic [bcrf_pkg::CFG_IDX_W-1:0] idx,
                              input logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= bcrf_pkg::CFG_COEF_CONST)
            coef_q[idx] = data;
        @(negedge clk);
    endtask

    task automatic apply_poly(input logic signed [31:0] c3, input logic signed [31:0] c2,
                              input logic signed [31:0] c1, input logic signed [31:0] c0);
        wait_idle();
        write_coef(bcrf_pkg::CFG_COEF_CUBIC, c3);
        write_coef(bcrf_pkg::CFG_COEF_SQUARE, c2);
        write_coef(bcrf_pkg::CFG_COEF_LINEAR, c1);
        write_coef(bcrf_pkg::CFG_COEF_CONST, c0);
        cfg_valid = 1'b0;
        poly_settings++;
    endtask

    // Mostly modest coefficients so roots land in reach; with wild set,
    // some coefficients take any 32-bit value to drive the saturation paths
    task automatic apply_random_poly(input bit wild);
        logic signed [31:0] c [4];
        int                 k;
        for (k = 0; k < 4; k++) begin
            if (wild && $urandom_range(3) == 0)
                c[k] = $urandom;
            else
                c[k] = $signed(32'($urandom)) >>> $urandom_range(8, 14);
        end
        apply_poly(c[0], c[1], c[2], c[3]);
    endtask

    // Offer one interval transaction; predict on acceptance and leave valid
    // high so a following call can change only the payload
    task automatic offer_interval(input logic signed [31:0] a, input logic signed [31:0] b,
                                  input logic [30:0] e);
        root_result_t want;
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid  = 1'b1;
        left_end  = a;
        right_end = b;
        tolerance = e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_bisection(a, b, e, want.root, want.limit_hit);
        expected_roots.push_back(want);
        items_sent++;
        @(negedge clk);
    endtask

    // Random interval: a fifth is raw noise over the full field ranges; the
    // rest are log-uniform widths around a center near the origin, some
    // reversed, with log-uniform or zero tolerance
    task automatic offer_random_interval();
        logic signed [31:0] a, b, center, t;
        logic [30:0]        e;
        longint             width;
        int                 kind;
        kind = $urandom_range(99);
        if (kind < 20) begin
            a = $urandom;
            b = $urandom;
            e = 31'($urandom);
        end else begin
            center = $signed(32'($urandom)) >>> $urandom_range(9, 31);
            width  = longint'($urandom >> $urandom_range(0, 31));
            a      = 32'(clamp32(longint'(center) - width / 2));
            b      = 32'(clamp32(longint'(a) + width));
            if ($urandom_range(3) == 0) begin
                t = a;
                a = b;
                b = t;
            end
            if ($urandom_range(99) < 15)
                e = '0;
            else
                e = 31'($urandom >> $urandom_range(1, 31));
        end
        offer_interval(a, b, e);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Throttle out_ready; a hold-off request overrides the random pattern
    always @(negedge clk)
        out_ready = !hold_results && ($urandom_range(99) >= recv_idle_pct);

    // Count out a long hold-off on its own so the sender keeps pushing
    initial begin
        forever begin
            wait (hold_len > 0);
            hold_results = 1'b1;
            repeat (hold_len) @(posedge clk);
            hold_results = 1'b0;
            hold_len     = 0;
        end
    end

    // Compare each accepted result against the oldest prediction
    always @(posedge clk) begin : result_check
        root_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_roots.size() == 0) begin
                $error("unexpected result transaction: root %0d iter_limit_hit %0b",
                       root, iter_limit_hit);
                mismatches++;
            end else begin
                want = expected_roots.pop_front();
                if (root !== want.root) begin
                    $error("root: expected %0d, actual %0d", want.root, root);
                    mismatches++;
                end
                if (iter_limit_hit !== want.limit_hit) begin
                    $error("iter_limit_hit: expected %0b, actual %0b",
                           want.limit_hit, iter_limit_hit);
                    mismatches++;
                end
                results_seen++;
                if (want.limit_hit)
                    cap_hits++;
            end
        end
    end

    // Watchdog: abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset polynomial x^3 + x - 4: field extremes, reversed and degenerate
    // intervals, zero and maximal tolerance
    task automatic test_reset_poly();
        offer_interval(32'sd0, 2 * Q1, 31'(Q1 >>> 10));
        offer_interval(Q_BOTTOM, Q_TOP, '0);
        offer_interval(Q_TOP, Q_BOTTOM, 31'd1);
        offer_interval(3 * Q1, 32'sd0, 31'(Q1 >>> 8));
        offer_interval(Q1, 2 * Q1, '0);
        offer_interval(Q1, Q1, '0);
        offer_interval(-Q1, 5 * Q1, TOL_TOP);
        offer_interval(32'sd0, 32'sd1, '0);
        offer_interval(-4 * Q1, -2 * Q1, 31'(Q1 >>> 12));
        offer_interval(Q_TOP - 1, Q_TOP, '0);
        wait_idle();
    endtask

    // 1 - x^2 has exact roots at +-1.0, so the zero branch of the sign test
    // fires; writes to unmapped indexes must leave the polynomial alone
    task automatic test_unit_parabola();
        apply_poly(32'sd0, -Q1, 32'sd0, Q1);
        write_coef(CFG_UNMAPPED_LO, $urandom);
        write_coef(CFG_UNMAPPED_HI, 32'hFFFF_FFFF);
        cfg_valid = 1'b0;
        offer_interval(Q1, 3 * Q1, '0);
        offer_interval(32'sd0, 3 * Q1, 31'd16);
        offer_interval(-3 * Q1, 32'sd0, 31'd16);
        offer_interval(-Q1, -Q1, '0);
        offer_interval(-Q1, Q1, '0);
        wait_idle();
    endtask

    // Extreme coefficients drive the Horner steps into saturation; the all-zero
    // polynomial always keeps the left half
    task automatic test_extreme_coefs();
        apply_poly(Q_TOP, Q_BOTTOM, Q_BOTTOM, Q_TOP);
        offer_interval(Q_BOTTOM, Q_TOP, '0);
        offer_interval(-Q1, Q1, '0);
        apply_poly(Q_BOTTOM, Q_TOP, Q_TOP, Q_BOTTOM);
        offer_interval(Q_TOP, 32'sd0, 31'd5);
        offer_interval(Q_BOTTOM, Q_BOTTOM + 1, '0);
        apply_poly(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        offer_interval(Q_BOTTOM, Q_TOP, '0);
        offer_interval(Q_TOP, Q_BOTTOM, '0);
        wait_idle();
    endtask

    // Bulk random intervals over three idle mixes and several polynomials
    task automatic test_random_intervals();
        int phase, chunk, n;
        for (phase = 0; phase < 3; phase++) begin
            for (chunk = 0; chunk < 3; chunk++) begin
                case (chunk)
                    0:       apply_poly(bcrf_pkg::RST_CUBIC, bcrf_pkg::RST_SQUARE,
                                        bcrf_pkg::RST_LINEAR, bcrf_pkg::RST_CONST);
                    1:       apply_random_poly(1'b0);
                    default: apply_random_poly(1'b1);
                endcase
                // switch idle mix only once the pipe has drained
                case (phase)
                    0: begin
                        send_idle_pct = 19;
                        recv_idle_pct = 85;
                    end
                    1: begin
                        send_idle_pct = 85;
                        recv_idle_pct = 19;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                for (n = 0; n < RANDOM_ITEMS / 9; n++)
                    offer_random_interval();
            end
        end
        wait_idle();
    endtask

    // Hold the result side off for a long stretch while the sender keeps
    // offering, so the output register fills and in_ready stays low
    task automatic test_result_hold_off();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = HOLD_CYCLES;
        for (n = 0; n < 8; n++)
            offer_random_interval();
        wait_idle();
    endtask

    initial begin
        // drive every input to a known value before reset releases
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bcrf_pkg::CFG_COEF_CUBIC;
        cfg_data  = '0;
        in_valid  = 1'b0;
        left_end  = '0;
        right_end = '0;
        tolerance = '0;
        out_ready = 1'b0;
        coef_q[bcrf_pkg::CFG_COEF_CUBIC]  = bcrf_pkg::RST_CUBIC;
        coef_q[bcrf_pkg::CFG_COEF_SQUARE] = bcrf_pkg::RST_SQUARE;
        coef_q[bcrf_pkg::CFG_COEF_LINEAR] = bcrf_pkg::RST_LINEAR;
        coef_q[bcrf_pkg::CFG_COEF_CONST]  = bcrf_pkg::RST_CONST;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners run under the first idle mix
        send_idle_pct = 19;
        recv_idle_pct = 85;
        test_reset_poly();
        test_unit_parabola();
        test_extreme_coefs();
        test_random_intervals();
        test_result_hold_off();

        // let a stray late transaction show up before judging
        repeat (ITEM_CYCLES) @(negedge clk);

        $display("Checked %0d results from %0d intervals over %0d coefficient sets, %0d capped.",
                 results_seen, items_sent, poly_settings, cap_hits);
        $display("Directed corners, random intervals under three idle mixes, %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
